FILE: rtl/core/bmlsu_pkg.sv
// Package for the byte memory load/store unit: codes, FSM state and control structs.
`default_nettype none
package bmlsu_pkg;

  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 40;

  localparam logic [2:0] CMD_LB  = 3'd0;
  localparam logic [2:0] CMD_LBU = 3'd1;
  localparam logic [2:0] CMD_LW  = 3'd2;
  localparam logic [2:0] CMD_SB  = 3'd3;
  localparam logic [2:0] CMD_SW  = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_ALIGN = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FINISH
  } bmlsu_state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_en;
    logic capture;
    logic exec;
    logic finish;
  } bmlsu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } bmlsu_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/byte_memory_load_store_unit.sv
// Top level of the byte memory load/store unit.
//
//  channel | dir | tdata fields (low bit up)                          | width
//  s_*     | in  | cmd[2:0] base_value[34:3] offset[66:35]            | 104
//          |     | store_value[98:67], zero pad                       |
//  m_*     | out | load_value[31:0] status[33:32], zero pad            | 40
//
// Each transaction has three steps: accept, memory access, result register load;
// the single-port word memory (registered read) sets this, so a new item waits for finish.
// After reset a clearing pass zeroes one word a cycle, all (MEM_BYTES+3)/4 words,
// with s_tready low.
// A new transaction is taken while a result waits in the output register; the
// following one waits in the finish step until m_tready frees that register.
`default_nettype none
module byte_memory_load_store_unit #(
  parameter int MEM_BYTES = 16384
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  input  wire [bmlsu_pkg::S_TDATA_W-1:0]  s_tdata,  // cmd, base_value, offset, store_value
  output logic                            m_tvalid,
  input  wire                             m_tready,
  output logic [bmlsu_pkg::M_TDATA_W-1:0] m_tdata   // load_value, status
);
  import bmlsu_pkg::*;

  bmlsu_cmd_t  dp_cmd;
  bmlsu_stat_t dp_stat;

  bmlsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .dp_stat  (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  bmlsu_dp #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat)
  );

endmodule
`default_nettype wire

FILE: rtl/core/bmlsu_ctrl.sv
// Controller state machine: clearing pass, accept, execute, result hand-off.
`default_nettype none
module bmlsu_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_tvalid,
  output logic                  s_tready,
  input  bmlsu_pkg::bmlsu_stat_t dp_stat,
  output bmlsu_pkg::bmlsu_cmd_t  dp_cmd
);
  import bmlsu_pkg::*;

  bmlsu_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    s_tready   = 1'b0;
    case (state)
      S_CLEAR: begin
        dp_cmd.clr_en = 1'b1;
        if (dp_stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          dp_cmd.capture = 1'b1;
          state_next     = S_EXEC;
        end
      end
      S_EXEC: begin
        dp_cmd.exec = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        // wait for the output register to be free
        if (dp_stat.out_free) begin
          dp_cmd.finish = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/bmlsu_dp.sv
// Datapath: address adder, checks, word-wide byte-enabled memory and result register.
`default_nettype none
module bmlsu_dp #(
  parameter int MEM_BYTES = 16384
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire [bmlsu_pkg::S_TDATA_W-1:0]     s_tdata,
  output logic [bmlsu_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  input  bmlsu_pkg::bmlsu_cmd_t              dp_cmd,
  output bmlsu_pkg::bmlsu_stat_t             dp_stat
);
  import bmlsu_pkg::*;

  localparam int WORDS = (MEM_BYTES + 3) / 4;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [31:0] BYTE_LIMIT = 32'(MEM_BYTES);
  localparam logic [31:0] WORD_LIMIT = 32'(MEM_BYTES - 4);

  logic [31:0] mem [WORDS];

  logic [2:0]    cmd_q;
  logic [31:0]   addr_q;
  logic [31:0]   data_q;
  logic [1:0]    stat_q;
  logic [31:0]   rdata_q;
  logic [AW-1:0] clr_idx;
  logic [31:0]   load_value_q;
  logic [1:0]    status_out_q;
  logic          out_valid;

  logic [1:0]    chk_stat;
  logic          is_byte, is_word, is_store;
  logic          wr_en;
  logic [3:0]    wr_be;
  logic [31:0]   wr_data;
  logic [AW-1:0] word_idx;
  logic [7:0]    lane_byte;
  logic [31:0]   value;

  assign word_idx = addr_q[AW+1:2];

  always_comb begin
    is_byte  = (cmd_q == CMD_LB) || (cmd_q == CMD_LBU) || (cmd_q == CMD_SB);
    is_word  = (cmd_q == CMD_LW) || (cmd_q == CMD_SW);
    is_store = (cmd_q == CMD_SB) || (cmd_q == CMD_SW);
    chk_stat = STAT_OK;
    if (is_byte) begin
      if (addr_q >= BYTE_LIMIT) chk_stat = STAT_RANGE;
    end else if (is_word) begin
      if (addr_q[1:0] != 2'b00)    chk_stat = STAT_ALIGN;
      else if (addr_q > WORD_LIMIT) chk_stat = STAT_RANGE;
    end
    wr_en = dp_cmd.exec && is_store && (chk_stat == STAT_OK);
    if (cmd_q == CMD_SW) begin
      wr_be   = 4'b1111;
      wr_data = data_q;
    end else begin
      wr_be   = 4'b0001 << addr_q[1:0];
      wr_data = {4{data_q[7:0]}};
    end
  end

  // capture the transaction, sum wraps at 32 bits; the check status is registered at exec
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_q  <= s_tdata[2:0];
      addr_q <= s_tdata[34:3] + s_tdata[66:35];
      data_q <= s_tdata[98:67];
    end
    if (dp_cmd.exec) begin
      stat_q <= chk_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (dp_cmd.clr_en) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.clr_en) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      for (int i = 0; i < 4; i++) begin
        if (wr_be[i]) mem[word_idx][8*i +: 8] <= wr_data[8*i +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      rdata_q <= mem[word_idx];
    end
  end

  always_comb begin
    case (addr_q[1:0])
      2'd0:    lane_byte = rdata_q[7:0];
      2'd1:    lane_byte = rdata_q[15:8];
      2'd2:    lane_byte = rdata_q[23:16];
      default: lane_byte = rdata_q[31:24];
    endcase
    if (stat_q != STAT_OK) begin
      value = '1;
    end else begin
      case (cmd_q)
        CMD_LB:  value = {{24{lane_byte[7]}}, lane_byte};
        CMD_LBU: value = {24'd0, lane_byte};
        CMD_LW:  value = rdata_q;
        default: value = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.finish) begin
      load_value_q <= value;
      status_out_q <= stat_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.finish) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign dp_stat.clr_last = (clr_idx == AW'(WORDS - 1));
  assign dp_stat.out_free = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, status_out_q, load_value_q};

endmodule
`default_nettype wire

FILE: rtl/core/bmlsu_checker.sv
// Port-level checker for the load/store unit, bound to the top level.
`default_nettype none
module bmlsu_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             s_tvalid,
  input wire                             s_tready,
  input wire                             m_tvalid,
  input wire                             m_tready,
  input wire [bmlsu_pkg::M_TDATA_W-1:0]  m_tdata
);
  import bmlsu_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // clearing pass follows reset
  a_clear_busy: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready during clearing pass");

  // one transaction in the core at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready straight after a transaction");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[33:32] != 2'd3)
    else $error("status code out of set");

  a_fault_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:32] != STAT_OK |-> m_tdata[31:0] == 32'hFFFF_FFFF)
    else $error("fault without all-ones load value");

endmodule

bind byte_memory_load_store_unit bmlsu_checker u_bmlsu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

FILE: dv/byte_memory_load_store_unit_checker.sv
// Checker for the byte memory load/store unit: predicts each access and compares results.
`timescale 1ns / 1ps
module byte_memory_load_store_unit_checker #(
  parameter int MEM_BYTES = 16384
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  input  wire                             s_tready,
  input  wire [bmlsu_pkg::S_TDATA_W-1:0]  s_tdata,
  input  wire                             m_tvalid,
  input  wire                             m_tready,
  input  wire [bmlsu_pkg::M_TDATA_W-1:0]  m_tdata,
  output int                              error_count,
  output int                              outstanding
);
  import bmlsu_pkg::*;

  localparam int IW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

  typedef struct packed {
    logic [31:0] load_value;
    logic [1:0]  status;
  } access_result_t;

  logic [7:0]     byte_image [MEM_BYTES];
  access_result_t pending_results [$];
  access_result_t want;
  access_result_t got;

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  // Applies one access to the shadow memory and returns what the unit should answer.
  function automatic access_result_t apply_access(logic [2:0] cmd, logic [31:0] base,
                                                  logic [31:0] offset, logic [31:0] data);
    access_result_t res;
    logic [31:0]    addr;
    logic [IW-1:0]  idx;
    addr           = base + offset;
    idx            = addr[IW-1:0];
    res.load_value = '0;
    res.status     = STAT_OK;
    case (cmd)
      CMD_LB, CMD_LBU, CMD_SB: begin
        // negative addresses are huge unsigned values, so one compare covers both ends
        if (addr >= 32'(MEM_BYTES)) begin
          res.status     = STAT_RANGE;
          res.load_value = '1;
        end else if (cmd == CMD_SB) begin
          byte_image[idx] = data[7:0];
        end else if (cmd == CMD_LB) begin
          res.load_value = {{24{byte_image[idx][7]}}, byte_image[idx]};
        end else begin
          res.load_value = {24'd0, byte_image[idx]};
        end
      end
      CMD_LW, CMD_SW: begin
        // alignment is judged before range
        if (addr[1:0] != 2'b00) begin
          res.status     = STAT_ALIGN;
          res.load_value = '1;
        end else if (addr > 32'(MEM_BYTES - 4)) begin
          res.status     = STAT_RANGE;
          res.load_value = '1;
        end else if (cmd == CMD_SW) begin
          byte_image[idx]            = data[7:0];
          byte_image[idx + IW'(1)]   = data[15:8];
          byte_image[idx + IW'(2)]   = data[23:16];
          byte_image[idx + IW'(3)]   = data[31:24];
        end else begin
          res.load_value = {byte_image[idx + IW'(3)], byte_image[idx + IW'(2)],
                            byte_image[idx + IW'(1)], byte_image[idx]};
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      byte_image = '{default: 8'd0};
      pending_results.delete();
      outstanding = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.load_value = m_tdata[31:0];
        got.status     = m_tdata[33:32];
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing expected: load_value %h status %0d",
                   $time, got.load_value, got.status);
        end else begin
          want = pending_results.pop_front();
          if (got.load_value !== want.load_value) begin
            error_count++;
            $display("%0t: load_value mismatch: expected %h actual %h",
                     $time, want.load_value, got.load_value);
          end
          if (got.status !== want.status) begin
            error_count++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, got.status);
          end
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(apply_access(s_tdata[2:0], s_tdata[34:3],
                                               s_tdata[66:35], s_tdata[98:67]));
      outstanding = pending_results.size();
    end
  end

endmodule

FILE: dv/tb_byte_memory_load_store_unit.sv
// Testbench top for the byte memory load/store unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_byte_memory_load_store_unit;
  import bmlsu_pkg::*;

  localparam int         MEM_BYTES     = 16384;
  localparam int         RANDOM_ITEMS  = 700;
  localparam int         HOLD_AT       = 300;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         DRAIN_AT      = 500;
  localparam int         IDLE_LIMIT    = 20000;
  localparam int         TAIL_CYCLES   = 20;
  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;

  logic                  s_taken = 1'b0;
  int                    sent_count = 0;
  int                    idle_cycles = 0;
  int                    error_count;
  int                    outstanding;

  always #5 clk = ~clk;

  byte_memory_load_store_unit #(.MEM_BYTES(MEM_BYTES)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  byte_memory_load_store_unit_checker #(.MEM_BYTES(MEM_BYTES)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  // input transaction seen at the last rising edge, read at the falling edge
  always @(posedge clk) s_taken <= s_tvalid && s_tready;

  // covers the clearing pass after reset and the long receiver hold
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap(bit burst);
    if (burst || $urandom_range(0, 1) == 0) return 0;
    return pick_stall();
  endfunction

  task automatic send_access(input logic [2:0] cmd, input logic [31:0] base,
                             input logic [31:0] offset, input logic [31:0] data,
                             input int gap);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = {{(S_TDATA_W - 99){1'b0}}, data, offset, base, cmd};
    s_tvalid = 1'b1;
    do @(negedge clk); while (!s_taken);
    sent_count++;
  endtask

  // Sends one access at the given address, splitting it into base and offset.
  task automatic send_at(input logic [2:0] cmd, input logic [31:0] addr,
                         input logic [31:0] data, input int gap);
    logic [31:0] offset;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: offset = $urandom_range(0, 4095) - 2048;
      5, 6, 7:       offset = $urandom;
      default:       offset = '0;
    endcase
    send_access(cmd, addr - offset, offset, data, gap);
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // receiver: ready runs, short and long stalls, and one long hold-off
  initial begin
    int  run_len;
    bit  hold_done;
    hold_done = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!hold_done && sent_count >= HOLD_AT) begin
        m_tready  = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      m_tready = 1'b1;
      run_len  = $urandom_range(1, 20);
      repeat (run_len) @(negedge clk);
      if ($urandom_range(0, 3) != 0) begin
        m_tready = 1'b0;
        run_len  = pick_stall();
        repeat (run_len) @(negedge clk);
      end
    end
  end

  initial begin
    logic [2:0]  cmd;
    logic [31:0] addr;
    int          r;
    bit          burst;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed corners
    send_access(CMD_SB,  32'd0,         32'd0,          32'h0000_00A5, 0);
    send_access(CMD_LB,  32'd0,         32'd0,          32'h0,         0);
    send_access(CMD_LBU, 32'd0,         32'd0,          32'h0,         0);
    send_access(CMD_SB,  32'd16384,     32'hFFFF_FFFF,  32'hFFFF_FF7F, 0);
    send_access(CMD_LB,  32'd16383,     32'd0,          32'h0,         0);
    send_access(CMD_SW,  32'd0,         32'd16380,      32'h80FF_1234, 0);
    send_access(CMD_LW,  32'd16380,     32'd0,          32'h0,         0);
    send_access(CMD_LB,  32'd16383,     32'd0,          32'h0,         0);
    send_access(CMD_LBU, 32'd16381,     32'd0,          32'h0,         0);
    // word past the end, misaligned word store and load, byte past the end
    send_access(CMD_LW,  32'd16384,     32'd0,          32'h0,         0);
    send_access(CMD_SW,  32'd16381,     32'd0,          32'hDEAD_BEEF, 0);
    send_access(CMD_LW,  32'd16382,     32'd0,          32'h0,         0);
    send_access(CMD_LB,  32'd16384,     32'd0,          32'h0,         0);
    // negative addresses, including wrap of the sum
    send_access(CMD_SB,  32'd0,         32'hFFFF_FFFF,  32'h0000_0011, 0);
    send_access(CMD_LW,  32'h8000_0000, 32'd0,          32'h0,         0);
    send_access(CMD_LB,  32'h7FFF_FFFF, 32'd1,          32'h0,         0);
    send_access(CMD_LBU, 32'hFFFF_FFFF, 32'd1,          32'h0,         0);
    send_access(CMD_SW,  32'h8000_0000, 32'h8000_0004,  32'hFFFF_FFFF, 0);
    send_access(CMD_LW,  32'd4,         32'd0,          32'h0,         0);
    // faulting store must leave memory untouched
    send_access(CMD_SW,  32'd6,         32'd0,          32'h0000_0000, 0);
    send_access(CMD_LW,  32'd4,         32'd0,          32'h0,         0);
    // spare commands do nothing
    send_access(CMD_SPARE_LO,         32'd0, 32'd0, 32'hFFFF_FFFF, 0);
    send_access(CMD_SPARE_LO + 3'd1,  32'd0, 32'd0, 32'hFFFF_FFFF, 0);
    send_access(CMD_SPARE_HI,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_access(CMD_LW,  32'd0,         32'd0,          32'h0,         0);

    wait_drained();

    burst = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 32 == 0) burst = ($urandom_range(0, 2) == 0);
      if (sent_count == DRAIN_AT) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 6) begin
        cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        send_access(cmd, $urandom, $urandom, $urandom, sender_gap(burst));
      end else if (r < 16) begin
        cmd = 3'($urandom_range(CMD_LB, CMD_SW));
        send_access(cmd, $urandom, $urandom, $urandom, sender_gap(burst));
      end else begin
        cmd = 3'($urandom_range(CMD_LB, CMD_SW));
        r   = $urandom_range(0, 99);
        if (r < 55) addr = $urandom_range(0, 127);
        else if (r < 80) addr = $urandom_range(MEM_BYTES - 128, MEM_BYTES - 1);
        else if (r < 92) addr = $urandom_range(0, MEM_BYTES - 1);
        else if (r < 96) addr = $urandom_range(MEM_BYTES - 4, MEM_BYTES + 8);
        else addr = 32'd0 - $urandom_range(1, 16);
        if ((cmd == CMD_LW || cmd == CMD_SW) && $urandom_range(0, 9) != 0)
          addr[1:0] = 2'b00;
        send_at(cmd, addr, $urandom, sender_gap(burst));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/bmlsu_pkg.sv
rtl/core/bmlsu_ctrl.sv
rtl/core/bmlsu_dp.sv
rtl/core/byte_memory_load_store_unit.sv
rtl/core/bmlsu_checker.sv
dv/byte_memory_load_store_unit_checker.sv
dv/tb_byte_memory_load_store_unit.sv
